// ===== hdl/wprhm_pkg.sv =====
// ----------------------------------------------------------------------------
// wprhm_pkg
// shared types and constants of the windowed peak / rms / hold level meter
// ----------------------------------------------------------------------------
package wprhm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int LEVEL_W     = 16;
  localparam int WLEN_W      = 13;
  localparam int HOLD_T_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int SQR_W       = 32;
  localparam int ROOT_STEPS  = 16;
  localparam int ROOT_REM_W  = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED        = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [WLEN_W-1:0]   WLEN_RESET   = 13'd480;
  localparam logic [HOLD_T_W-1:0] HOLD_T_RESET = 16'd500;

  typedef struct packed {
    logic                       cmd;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic               meter_channel;
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] hold;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic update;
    logic div_step;
    logic root_load;
    logic root_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic win_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/windowed_peak_rms_hold_meter_core.sv =====
// ----------------------------------------------------------------------------
// windowed_peak_rms_hold_meter_core
// per-channel windowed peak and rms level meter with timed peak hold
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in_      input      in_valid/in_ready    in_item_t  (cmd, channel, sample)
// out_     output     out_valid/out_ready  out_item_t (meter_channel, peak, rms, hold)
// cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// a tick or a dropped sample is taken in the idle state; a sample inside a window
// passes through the square and update states; a sample that ends a window also
// runs the bit-serial divider, the root load and root steps, and the output state
// one transaction at a time; a full output register stalls only the output state
// reset is synchronous, active low, and clears all window, hold and tick state
// ----------------------------------------------------------------------------
module windowed_peak_rms_hold_meter_core #(
  parameter int CHANNELS   = 2,
  parameter int MAX_WINDOW = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wprhm_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wprhm_pkg::out_item_t             out_data,
  input  logic                             cfg_we,
  input  logic [wprhm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wprhm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wprhm_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 31 + CNT_W;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wprhm_ctrl #(
    .SUM_W (SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wprhm_dpath #(
    .CHANNELS   (CHANNELS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== hdl/wprhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// wprhm_ctrl
// sequencer: sample square, window update, bit-serial divide, root, result
// ----------------------------------------------------------------------------
module wprhm_ctrl #(
  parameter int SUM_W = 44
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wprhm_pkg::dp_status_t status,
  output wprhm_pkg::ctrl_cmd_t  cmd
);
  import wprhm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              div_last, root_last;

  assign div_last  = (step_r == DIV_LAST);
  assign root_last = (step_r == ROOT_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && status.sample_ok) state_nxt = ST_SQUARE;
      end
      ST_SQUARE:    state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        state_nxt = status.win_done ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (div_last) state_nxt = ST_ROOT_LOAD;
      end
      ST_ROOT_LOAD: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_last) state_nxt = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    step_nxt = '0;
    if ((state_r == ST_DIVIDE && !div_last) || (state_r == ST_ROOT && !root_last)) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SQUARE:    cmd.square    = 1'b1;
      ST_UPDATE:    cmd.update    = 1'b1;
      ST_DIVIDE:    cmd.div_step  = 1'b1;
      ST_ROOT_LOAD: cmd.root_load = 1'b1;
      ST_ROOT:      cmd.root_step = 1'b1;
      ST_OUTPUT:    cmd.out_load  = status.out_free;
      default:      cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIVIDE && state_r != ST_ROOT) |-> step_r == '0)
    else $error("step counter running outside divide and root");

  a_divide_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE && div_last) |=> state_r == ST_ROOT_LOAD)
    else $error("divide did not end after its last step");

  a_update_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQUARE |=> state_r == ST_UPDATE)
    else $error("square not followed by update");

endmodule

// ===== hdl/wprhm_dpath.sv =====
// ----------------------------------------------------------------------------
// wprhm_dpath
// config registers, tick counter, per-channel window state, divider, root
// ----------------------------------------------------------------------------
module wprhm_dpath #(
  parameter int CHANNELS   = 2,
  parameter int MAX_WINDOW = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wprhm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wprhm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wprhm_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wprhm_pkg::out_item_t                out_data,
  input  wprhm_pkg::ctrl_cmd_t                cmd,
  output wprhm_pkg::dp_status_t               status
);
  import wprhm_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 31 + CNT_W;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [31:0] MAXW = 32'(MAX_WINDOW);
  localparam logic [31:0] CHN  = 32'(CHANNELS);

  // config and tick state
  logic [WLEN_W-1:0]   wlen_r;
  logic [HOLD_T_W-1:0] hold_t_r;
  logic                paused_r;
  logic [HOLD_T_W-1:0] tick_r, tick_inc, limit;
  logic                tick_clear, is_tick;

  // per-channel window state
  logic [CNT_W-1:0]   cnt_r  [CHANNELS];
  logic [SUM_W-1:0]   sum_r  [CHANNELS];
  logic [LEVEL_W-1:0] peak_r [CHANNELS];
  logic [LEVEL_W-1:0] hold_r [CHANNELS];

  // sample pipeline
  logic [CH_W-1:0]    c_r;
  logic [LEVEL_W-1:0] mag_r, mag;
  logic [SQR_W-1:0]   sq_r;

  logic [31:0]        len32;
  logic [CNT_W-1:0]   len, cnt_new;
  logic [SUM_W-1:0]   sum_new;
  logic [LEVEL_W-1:0] peak_new, hold_new;
  logic               win_done, wlen_write;

  // result staging
  logic               res_ch_r;
  logic [LEVEL_W-1:0] res_peak_r, res_hold_r;

  // bit-serial divider
  logic [SUM_W-1:0]   q_r;
  logic [CNT_W-1:0]   dvs_r, rem_r;
  logic [CNT_W:0]     div_sh;
  logic               div_ge;

  // two bits a step square root
  logic [31:0]           x_r;
  logic [ROOT_REM_W-1:0] sr_r;
  logic [LEVEL_W-1:0]    root_r;
  logic [ROOT_REM_W+1:0] root_sh, root_trial;
  logic                  root_ge;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  assign is_tick    = (in_data.cmd == CMD_TICK);
  assign limit      = (hold_t_r == '0) ? HOLD_T_W'(1) : hold_t_r;
  assign tick_inc   = tick_r + 1'b1;
  assign tick_clear = cmd.load && is_tick && (tick_inc >= limit);
  assign wlen_write = cfg_we && (cfg_index == CFG_WINDOW_LENGTH);

  assign mag = in_data.sample[SAMPLE_W-1] ? (LEVEL_W'(~in_data.sample) + 1'b1)
                                          : LEVEL_W'(in_data.sample);

  assign len32 = (wlen_r == '0) ? 32'd1 : ((32'(wlen_r) > MAXW) ? MAXW : 32'(wlen_r));
  assign len   = len32[CNT_W-1:0];

  assign cnt_new  = cnt_r[c_r] + 1'b1;
  assign sum_new  = sum_r[c_r] + SUM_W'(sq_r);
  assign peak_new = (mag_r > peak_r[c_r]) ? mag_r : peak_r[c_r];
  assign hold_new = (hold_r[c_r] > peak_new) ? hold_r[c_r] : peak_new;
  assign win_done = (cnt_new >= len);

  assign div_sh = {rem_r, q_r[SUM_W-1]};
  assign div_ge = (div_sh >= {1'b0, dvs_r});

  assign root_sh    = {sr_r, x_r[31:30]};
  assign root_trial = {2'b00, root_r, 2'b01};
  assign root_ge    = (root_sh >= root_trial);

  assign status.sample_ok = !is_tick && !paused_r && (32'(in_data.channel) < CHN);
  assign status.win_done  = win_done;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config and tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r   <= WLEN_RESET;
      hold_t_r <= HOLD_T_RESET;
      paused_r <= 1'b0;
      tick_r   <= '0;
    end else begin
      if (tick_clear) begin
        tick_r <= '0;
      end else if (cmd.load && is_tick) begin
        tick_r <= tick_inc;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_LENGTH: wlen_r <= cfg_wdata[WLEN_W-1:0];
          CFG_HOLD_TIME: begin
            hold_t_r <= cfg_wdata[HOLD_T_W-1:0];
            tick_r   <= '0;
          end
          CFG_PAUSED:        paused_r <= cfg_wdata[0];
          default:           ;
        endcase
      end
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i]  <= '0;
        sum_r[i]  <= '0;
        peak_r[i] <= '0;
        hold_r[i] <= '0;
      end
    end else begin
      if (cmd.update) begin
        if (win_done) begin
          cnt_r[c_r]  <= '0;
          sum_r[c_r]  <= '0;
          peak_r[c_r] <= '0;
          hold_r[c_r] <= hold_new;
        end else begin
          cnt_r[c_r]  <= cnt_new;
          sum_r[c_r]  <= sum_new;
          peak_r[c_r] <= peak_new;
        end
      end
      if (wlen_write) begin
        for (int i = 0; i < CHANNELS; i++) begin
          cnt_r[i]  <= '0;
          sum_r[i]  <= '0;
          peak_r[i] <= '0;
        end
      end
      if (tick_clear) begin
        for (int i = 0; i < CHANNELS; i++) begin
          hold_r[i] <= '0;
        end
      end
    end
  end

  // sample, divide and root datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r   <= CH_W'(in_data.channel);
      mag_r <= mag;
    end
    if (cmd.square) begin
      sq_r <= mag_r * mag_r;
    end
    if (cmd.update && win_done) begin
      res_ch_r   <= c_r[0];
      res_peak_r <= peak_new;
      res_hold_r <= hold_new;
      q_r        <= sum_new;
      dvs_r      <= cnt_new;
      rem_r      <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? CNT_W'(div_sh - {1'b0, dvs_r}) : div_sh[CNT_W-1:0];
      q_r   <= {q_r[SUM_W-2:0], div_ge};
    end
    if (cmd.root_load) begin
      x_r    <= {1'b0, q_r[30:0]};
      sr_r   <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      sr_r   <= root_ge ? ROOT_REM_W'(root_sh - root_trial) : ROOT_REM_W'(root_sh);
      root_r <= {root_r[LEVEL_W-2:0], root_ge};
      x_r    <= {x_r[29:0], 2'b00};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.meter_channel <= res_ch_r;
      out_data_r.peak          <= res_peak_r;
      out_data_r.rms           <= root_r;
      out_data_r.hold          <= res_hold_r;
    end
  end

  a_tick_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r < limit)
    else $error("tick count reached hold limit");

  a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update && win_done |=> cnt_r[$past(c_r)] == '0)
    else $error("completed window not cleared");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_data_r.rms <= 16'h8000)
    else $error("rms above full scale");

  a_hold_covers_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.peak <= out_data_r.hold)
    else $error("hold below peak");

endmodule
